/* rtl/mhpq_pkg.sv */
package mhpq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = ADDR_W + 2;
  localparam int KEY_W     = 32;
  localparam int OUT_CNT_W = 11;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t  op;
    key_t value;
  } in_item_t;

  typedef struct packed {
    key_t                 max_value;
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_OUT
  } state_t;

endpackage

/* rtl/mhpq_ram.sv */
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mhpq_ctrl.sv */
module mhpq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mhpq_pkg::in_item_t   in_data,
  output mhpq_pkg::ram_req_t   ram_req,
  input  mhpq_pkg::key_t       ram_rdata,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mhpq_pkg::out_item_t  res_data
);

  mhpq_pkg::state_t  state_r, state_nxt;
  mhpq_pkg::addr_t   pos_r, pos_nxt;
  mhpq_pkg::addr_t   par_r, par_nxt;
  mhpq_pkg::addr_t   cand_idx_r, cand_idx_nxt;
  mhpq_pkg::key_t    cand_val_r, cand_val_nxt;
  mhpq_pkg::key_t    key_r, key_nxt;
  mhpq_pkg::key_t    res_val_r, res_val_nxt;
  mhpq_pkg::status_t res_st_r, res_st_nxt;
  mhpq_pkg::cnt_t    cnt_r, cnt_nxt;

  logic [mhpq_pkg::IDX_W-1:0] lft, rgt, cnt_ext;
  mhpq_pkg::addr_t            pos_m1, par_calc;

  assign lft      = {1'b0, pos_r, 1'b1};
  assign rgt      = {1'b0, pos_r, 1'b0} + mhpq_pkg::IDX_W'(2);
  assign cnt_ext  = mhpq_pkg::IDX_W'(cnt_r);
  assign pos_m1   = pos_r - mhpq_pkg::addr_t'(1);
  assign par_calc = pos_m1 >> 1;

  assign res_data.max_value = res_val_r;
  assign res_data.status    = res_st_r;
  assign res_data.count     = mhpq_pkg::OUT_CNT_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    par_r      <= par_nxt;
    cand_idx_r <= cand_idx_nxt;
    cand_val_r <= cand_val_nxt;
    key_r      <= key_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
  end

  always_comb begin
    mhpq_pkg::key_t  dec_val;
    mhpq_pkg::addr_t dec_idx;
    logic            decide;

    state_nxt    = state_r;
    pos_nxt      = pos_r;
    par_nxt      = par_r;
    cand_idx_nxt = cand_idx_r;
    cand_val_nxt = cand_val_r;
    key_nxt      = key_r;
    res_val_nxt  = res_val_r;
    res_st_nxt   = res_st_r;
    cnt_nxt      = cnt_r;
    ram_req      = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    dec_val      = cand_val_r;
    dec_idx      = cand_idx_r;
    decide       = 1'b0;

    case (state_r)
      mhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_val_nxt = '0;
          res_st_nxt  = mhpq_pkg::ST_OK;
          if (in_data.op == mhpq_pkg::OP_INSERT) begin
            if (cnt_r == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
              res_st_nxt = mhpq_pkg::ST_FULL;
              state_nxt  = mhpq_pkg::S_OUT;
            end else begin
              key_nxt   = in_data.value;
              pos_nxt   = cnt_r[mhpq_pkg::ADDR_W-1:0];
              cnt_nxt   = cnt_r + mhpq_pkg::cnt_t'(1);
              state_nxt = mhpq_pkg::S_UP_CHK;
            end
          end else if (cnt_r == '0) begin
            res_st_nxt = mhpq_pkg::ST_EMPTY;
            state_nxt  = mhpq_pkg::S_OUT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            cnt_nxt       = cnt_r - mhpq_pkg::cnt_t'(1);
            state_nxt     = mhpq_pkg::S_EX_ROOT;
          end
        end
      end
      mhpq_pkg::S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = key_r;
          state_nxt     = mhpq_pkg::S_OUT;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = par_calc;
          par_nxt       = par_calc;
          state_nxt     = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        // parent smaller: it drops into the hole and the hole climbs
        if (ram_rdata < key_r) begin
          ram_req.wdata = ram_rdata;
          pos_nxt       = par_r;
          state_nxt     = mhpq_pkg::S_UP_CHK;
        end else begin
          ram_req.wdata = key_r;
          state_nxt     = mhpq_pkg::S_OUT;
        end
      end
      mhpq_pkg::S_EX_ROOT: begin
        res_val_nxt   = ram_rdata;
        ram_req.re    = 1'b1;
        ram_req.raddr = cnt_r[mhpq_pkg::ADDR_W-1:0];
        state_nxt     = mhpq_pkg::S_EX_LAST;
      end
      mhpq_pkg::S_EX_LAST: begin
        key_nxt   = ram_rdata;
        pos_nxt   = '0;
        state_nxt = mhpq_pkg::S_DN_CHK;
      end
      mhpq_pkg::S_DN_CHK: begin
        if (lft < cnt_ext) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = lft[mhpq_pkg::ADDR_W-1:0];
          state_nxt     = mhpq_pkg::S_DN_L;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = key_r;
          state_nxt     = mhpq_pkg::S_OUT;
        end
      end
      mhpq_pkg::S_DN_L: begin
        // left child wins a tie with the right one
        if (key_r < ram_rdata) begin
          dec_val = ram_rdata;
          dec_idx = lft[mhpq_pkg::ADDR_W-1:0];
        end else begin
          dec_val = key_r;
          dec_idx = pos_r;
        end
        if (rgt < cnt_ext) begin
          cand_val_nxt  = dec_val;
          cand_idx_nxt  = dec_idx;
          ram_req.re    = 1'b1;
          ram_req.raddr = rgt[mhpq_pkg::ADDR_W-1:0];
          state_nxt     = mhpq_pkg::S_DN_R;
        end else begin
          decide = 1'b1;
        end
      end
      mhpq_pkg::S_DN_R: begin
        if (cand_val_r < ram_rdata) begin
          dec_val = ram_rdata;
          dec_idx = rgt[mhpq_pkg::ADDR_W-1:0];
        end
        decide = 1'b1;
      end
      mhpq_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase

    if (decide) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = pos_r;
      if (dec_idx == pos_r) begin
        ram_req.wdata = key_r;
        state_nxt     = mhpq_pkg::S_OUT;
      end else begin
        ram_req.wdata = dec_val;
        pos_nxt       = dec_idx;
        state_nxt     = mhpq_pkg::S_DN_CHK;
      end
    end
  end

endmodule

/* rtl/max_heap_priority_queue_unit.sv */
// Flow, input transfer to out_valid: a refused insert or an empty extract goes
// straight to the result; an insert reads and compares one parent per level;
// an extract reads root and last entry, then per level descended the left and
// any right child (one RAM read port: children fetched one after another).
// One item in flight; in_ready returns once the result is in the output register.
// Reset (rst_n, synchronous) empties the queue; heap RAM is not cleared.
module max_heap_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::out_item_t out_data
);

  mhpq_pkg::ram_req_t  ram_req;
  mhpq_pkg::key_t      ram_rdata;
  mhpq_pkg::out_item_t res_data;
  logic                res_valid, res_ready;
  logic                out_valid_r;
  mhpq_pkg::out_item_t out_data_r;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  mhpq_ram #(
    .WIDTH (mhpq_pkg::KEY_W),
    .DEPTH (mhpq_pkg::CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register frees as the pending transfer completes
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/mhpq_chk.sv */
module mhpq_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mhpq_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mhpq_pkg::ST_EMPTY |->
      out_data.max_value == '0 && out_data.count == '0)
    else $error("empty extract with nonzero value or count");

  a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mhpq_pkg::ST_FULL |->
      out_data.max_value == '0 &&
      out_data.count == mhpq_pkg::OUT_CNT_W'(mhpq_pkg::CAPACITY))
    else $error("refused insert with wrong value or count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind max_heap_priority_queue_unit mhpq_chk u_mhpq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
